// ----- hdl/prs_pkg.sv -----
// Shared types and constants for the power rail sequencer.
// No dependencies; used by prs_regs, prs_step, power_rail_sequencer_core and tb_top.
`default_nettype none

package prs_pkg;

  localparam int unsigned THR_W    = 10;
  localparam int unsigned BUDGET_W = 8;
  localparam int unsigned RUN_W    = 4;
  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned DATA_W   = 32;

  localparam logic [THR_W-1:0]    CHECK_THR_RST   = 10'd50;
  localparam logic [THR_W-1:0]    ON_THR_RST      = 10'd400;
  localparam logic [THR_W-1:0]    OFF_THR_RST     = 10'd40;
  localparam logic [BUDGET_W-1:0] RISE_BUDGET_RST = 8'd50;
  localparam logic [BUDGET_W-1:0] FALL_BUDGET_RST = 8'd100;
  localparam logic [RUN_W-1:0]    RUN_NEEDED_RST  = 4'd6;
  localparam logic                LED_LEVEL_RST   = 1'b0;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_CHECK = 2'd1,
    OP_ON    = 2'd2,
    OP_OFF   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_CHECK = 2'd1,
    MODE_ON    = 2'd2,
    MODE_OFF   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_NONE    = 3'd0,
    ST_OK      = 3'd1,
    ST_ABSENT  = 3'd2,
    ST_TIMEOUT = 3'd3,
    ST_IGNORED = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    REG_CHECK_THR   = 3'd0,
    REG_ON_THR      = 3'd1,
    REG_OFF_THR     = 3'd2,
    REG_RISE_BUDGET = 3'd3,
    REG_FALL_BUDGET = 3'd4,
    REG_RUN_NEEDED  = 3'd5,
    REG_LED_LEVEL   = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [THR_W-1:0]    check_thr;
    logic [THR_W-1:0]    on_thr;
    logic [THR_W-1:0]    off_thr;
    logic [BUDGET_W-1:0] rise_budget;
    logic [BUDGET_W-1:0] fall_budget;
    logic [RUN_W-1:0]    run_needed;
    logic                led_level;
  } cfg_t;

  typedef struct packed {
    logic                good;
    logic                enable;
    logic                led;
    mode_e               mode;
    logic [RUN_W-1:0]    high_run;
    logic [BUDGET_W-1:0] ticks;
  } seq_state_t;

endpackage

`default_nettype wire

// ----- hdl/prs_regs.sv -----
// APB-style configuration register bank for the power rail sequencer.
// Depends on prs_pkg (cfg_t, register indexes, reset values).
`default_nettype none

module prs_regs import prs_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output cfg_t                   cfg_o
);

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e idx;

  assign wr_en = psel & penable & pwrite;
  assign idx   = reg_idx_e'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.check_thr   <= CHECK_THR_RST;
      cfg_q.on_thr      <= ON_THR_RST;
      cfg_q.off_thr     <= OFF_THR_RST;
      cfg_q.rise_budget <= RISE_BUDGET_RST;
      cfg_q.fall_budget <= FALL_BUDGET_RST;
      cfg_q.run_needed  <= RUN_NEEDED_RST;
      cfg_q.led_level   <= LED_LEVEL_RST;
    end else if (wr_en) begin
      case (idx)
        REG_CHECK_THR:   cfg_q.check_thr   <= pwdata[THR_W-1:0];
        REG_ON_THR:      cfg_q.on_thr      <= pwdata[THR_W-1:0];
        REG_OFF_THR:     cfg_q.off_thr     <= pwdata[THR_W-1:0];
        REG_RISE_BUDGET: cfg_q.rise_budget <= pwdata[BUDGET_W-1:0];
        REG_FALL_BUDGET: cfg_q.fall_budget <= pwdata[BUDGET_W-1:0];
        REG_RUN_NEEDED:  cfg_q.run_needed  <= pwdata[RUN_W-1:0];
        REG_LED_LEVEL:   cfg_q.led_level   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CHECK_THR:   prdata = DATA_W'(cfg_q.check_thr);
      REG_ON_THR:      prdata = DATA_W'(cfg_q.on_thr);
      REG_OFF_THR:     prdata = DATA_W'(cfg_q.off_thr);
      REG_RISE_BUDGET: prdata = DATA_W'(cfg_q.rise_budget);
      REG_FALL_BUDGET: prdata = DATA_W'(cfg_q.fall_budget);
      REG_RUN_NEEDED:  prdata = DATA_W'(cfg_q.run_needed);
      REG_LED_LEVEL:   prdata = DATA_W'(cfg_q.led_level);
      default:         prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- hdl/prs_step.sv -----
// Per-sample sequencer logic: command decode, debounce run, tick budget.
// Purely combinational; depends on prs_pkg.
`default_nettype none

module prs_step import prs_pkg::*; #(
  parameter int unsigned ADC_BITS = 10
) (
  input  wire cfg_t                 cfg_i,
  input  wire seq_state_t           cur_i,
  input  wire op_e                  op_i,
  input  wire logic  [ADC_BITS-1:0] voltage_i,
  output seq_state_t                nxt_o,
  output status_e                   status_o
);

  localparam int unsigned CW = (ADC_BITS > THR_W) ? ADC_BITS : THR_W;

  logic [CW-1:0]       v, chk_thr, on_thr, off_thr, thr;
  logic [RUN_W-1:0]    run_min;
  logic [BUDGET_W-1:0] rise_min, fall_min;

  assign v        = CW'(voltage_i);
  assign chk_thr  = CW'(cfg_i.check_thr);
  assign on_thr   = CW'(cfg_i.on_thr);
  assign off_thr  = CW'(cfg_i.off_thr);
  // zero budget or run length behaves as one
  assign run_min  = (cfg_i.run_needed == '0) ? RUN_W'(1) : cfg_i.run_needed;
  assign rise_min = (cfg_i.rise_budget == '0) ? BUDGET_W'(1) : cfg_i.rise_budget;
  assign fall_min = (cfg_i.fall_budget == '0) ? BUDGET_W'(1) : cfg_i.fall_budget;

  always_comb begin
    mode_e               m;
    logic [RUN_W-1:0]    hr;
    logic [BUDGET_W-1:0] tl;
    logic                run_en;
    logic                done;

    nxt_o    = cur_i;
    status_o = ST_NONE;
    m        = cur_i.mode;
    hr       = cur_i.high_run;
    tl       = cur_i.ticks;
    run_en   = 1'b0;
    done     = 1'b0;
    thr      = on_thr;

    if (cur_i.mode != MODE_IDLE) begin
      run_en = 1'b1;
    end else begin
      case (op_i)
        OP_CHECK: begin
          if (cur_i.good && (v > chk_thr)) begin
            status_o = ST_OK;
          end else if (v <= chk_thr) begin
            nxt_o.good = 1'b0;
            nxt_o.led  = 1'b0;
            status_o   = ST_ABSENT;
          end else begin
            m      = MODE_CHECK;
            hr     = '0;
            tl     = rise_min;
            run_en = 1'b1;
          end
        end
        OP_ON: begin
          nxt_o.enable = 1'b1;
          m            = MODE_ON;
          hr           = '0;
          tl           = rise_min;
          run_en       = 1'b1;
        end
        OP_OFF: begin
          nxt_o.enable = 1'b0;
          m            = MODE_OFF;
          hr           = '0;
          tl           = fall_min;
          run_en       = 1'b1;
        end
        default: ;
      endcase
    end

    if (run_en) begin
      thr = (m == MODE_CHECK) ? chk_thr : on_thr;
      if (m == MODE_OFF) begin
        if (v < off_thr) begin
          nxt_o.good = 1'b0;
          m          = MODE_IDLE;
          status_o   = ST_OK;
          done       = 1'b1;
        end
      end else if (v > thr) begin
        if (hr != {RUN_W{1'b1}}) hr = hr + RUN_W'(1);
        if (hr >= run_min) begin
          nxt_o.good = 1'b1;
          if (m == MODE_CHECK) nxt_o.led = 1'b1;
          m        = MODE_IDLE;
          status_o = ST_OK;
          done     = 1'b1;
        end
      end else begin
        hr = '0;
      end

      if (!done) begin
        if (tl != '0) tl = tl - BUDGET_W'(1);
        if (tl == '0) begin
          // a timed-out check drops power-good and the LED
          if (m == MODE_CHECK) begin
            nxt_o.good = 1'b0;
            nxt_o.led  = 1'b0;
          end
          m        = MODE_IDLE;
          status_o = ST_TIMEOUT;
        end
      end
    end

    if ((cur_i.mode != MODE_IDLE) && (op_i != OP_TICK) && (status_o == ST_NONE)) begin
      status_o = ST_IGNORED;
    end

    nxt_o.mode     = m;
    nxt_o.high_run = hr;
    nxt_o.ticks    = tl;
  end

endmodule

`default_nettype wire

// ----- hdl/power_rail_sequencer_core.sv -----
// Power rail sequencer: one sample item in, one status item out.
// An accepted item moves from the input register to the result register.
// Throughput: one item per cycle; the sequence state updates as an item moves
// to the result register. A stalled result holds the input register.
// Reset: clears the sequence state, flags and valid bits; config registers return to defaults.
// Depends on prs_pkg, prs_regs and prs_step.
`default_nettype none

module power_rail_sequencer_core import prs_pkg::*; #(
  parameter int unsigned ADC_BITS = 10
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // sample items
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [1:0]          op_i,
  input  wire logic [ADC_BITS-1:0] voltage_i,
  // result items
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic                     power_good_o,
  output logic                     enable_out_o,
  output logic                     led_pin_o,
  output logic                     busy_res_o,
  output logic [2:0]               status_o,
  // configuration
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ADDR_W-1:0]   paddr,
  input  wire logic [DATA_W-1:0]   pwdata,
  output logic      [DATA_W-1:0]   prdata,
  output logic                     pready
);

  cfg_t          cfg;
  seq_state_t    state_q, state_d;
  status_e       step_status;

  logic                in_valid_q;
  op_e                 in_op_q;
  logic [ADC_BITS-1:0] in_volt_q;
  logic                out_valid_q;
  logic                advance;
  logic                in_accept;

  logic                res_good_q, res_enable_q, res_led_q, res_busy_q;
  status_e             res_status_q;

  assign pready = 1'b1;

  prs_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  prs_step #(.ADC_BITS(ADC_BITS)) u_step (
    .cfg_i     (cfg),
    .cur_i     (state_q),
    .op_i      (in_op_q),
    .voltage_i (in_volt_q),
    .nxt_o     (state_d),
    .status_o  (step_status)
  );

  // input register moves on unless the result register is held
  assign advance    = in_valid_q & ~(out_valid_q & out_stall_i);
  assign in_stall_o = in_valid_q & out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{good: 1'b0, enable: 1'b0, led: 1'b0, mode: MODE_IDLE,
                       high_run: '0, ticks: '0};
    end else begin
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_op_q   <= op_e'(op_i);
      in_volt_q <= voltage_i;
    end
    if (advance) begin
      res_good_q   <= state_d.good;
      res_enable_q <= state_d.enable;
      res_led_q    <= state_d.led ? cfg.led_level : ~cfg.led_level;
      res_busy_q   <= (state_d.mode != MODE_IDLE);
      res_status_q <= step_status;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign power_good_o = res_good_q;
  assign enable_out_o = res_enable_q;
  assign led_pin_o    = res_led_q;
  assign busy_res_o   = res_busy_q;
  assign status_o     = res_status_q;

  a_ignored_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_IGNORED) |-> busy_res_o)
    else $error("ignored command reported with no sequence running");

  a_finish_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((status_o == ST_OK) || (status_o == ST_ABSENT) ||
    (status_o == ST_TIMEOUT)) |-> !busy_res_o)
    else $error("finished status reported while sequence still busy");

  a_absent_not_good: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_ABSENT) |-> !power_good_o)
    else $error("rail absent reported with power-good set");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> in_valid_q && out_valid_q)
    else $error("stalled input item lost");

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench for power_rail_sequencer_core: sample items are checked against a local sequencer model.
// Depends on prs_pkg and the power_rail_sequencer_core RTL.

module tb_top;
  import prs_pkg::*;

  localparam int unsigned VOLT_W = 10;

  typedef struct packed {
    logic    good;
    logic    enable;
    logic    led;
    logic    busy;
    status_e status;
  } rail_result_t;

  logic              clk_i      = 1'b0;
  logic              rst_ni     = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [1:0]        op_i       = '0;
  logic [VOLT_W-1:0] voltage_i  = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              power_good_o;
  logic              enable_out_o;
  logic              led_pin_o;
  logic              busy_res_o;
  logic [2:0]        status_o;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [DATA_W-1:0] pwdata  = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  power_rail_sequencer_core #(.ADC_BITS(VOLT_W)) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .voltage_i    (voltage_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .power_good_o (power_good_o),
    .enable_out_o (enable_out_o),
    .led_pin_o    (led_pin_o),
    .busy_res_o   (busy_res_o),
    .status_o     (status_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // local copy of the sequencer: registers and sequence state
  cfg_t         rail_cfg;
  seq_state_t   rail_st;
  rail_result_t rail_status_q[$];

  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned result_cnt   = 0;

  // ---------------------------------------------------------------- sequencer model

  function automatic void seq_start(mode_e mode, logic [BUDGET_W-1:0] budget);
    rail_st.mode     = mode;
    rail_st.high_run = '0;
    rail_st.ticks    = (budget == 0) ? 8'd1 : budget;
  endfunction

  // evaluates one sample in the running sequence
  function automatic status_e seq_advance(logic [VOLT_W-1:0] v);
    logic [RUN_W-1:0] run_goal;
    logic [THR_W-1:0] thr;
    run_goal = (rail_cfg.run_needed == 0) ? 4'd1 : rail_cfg.run_needed;
    if (rail_st.mode == MODE_OFF) begin
      if (v < rail_cfg.off_thr) begin
        rail_st.good = 1'b0;
        rail_st.mode = MODE_IDLE;
        return ST_OK;
      end
    end else begin
      thr = (rail_st.mode == MODE_CHECK) ? rail_cfg.check_thr : rail_cfg.on_thr;
      if (v > thr) begin
        if (rail_st.high_run < 4'd15) rail_st.high_run = rail_st.high_run + 1'b1;
        if (rail_st.high_run >= run_goal) begin
          rail_st.good = 1'b1;
          if (rail_st.mode == MODE_CHECK) rail_st.led = 1'b1;
          rail_st.mode = MODE_IDLE;
          return ST_OK;
        end
      end else begin
        rail_st.high_run = '0;
      end
    end
    if (rail_st.ticks > 0) rail_st.ticks = rail_st.ticks - 1'b1;
    if (rail_st.ticks == 0) begin
      if (rail_st.mode == MODE_CHECK) begin
        rail_st.good = 1'b0;
        rail_st.led  = 1'b0;
      end
      rail_st.mode = MODE_IDLE;
      return ST_TIMEOUT;
    end
    return ST_NONE;
  endfunction

  function automatic void predict_rail_step(op_e op, logic [VOLT_W-1:0] v);
    status_e      st;
    rail_result_t r;
    st = ST_NONE;
    if (rail_st.mode != MODE_IDLE) begin
      st = seq_advance(v);
      if (op != OP_TICK && st == ST_NONE) st = ST_IGNORED;
    end else if (op == OP_CHECK) begin
      if (rail_st.good && v > rail_cfg.check_thr) begin
        st = ST_OK;
      end else if (v <= rail_cfg.check_thr) begin
        rail_st.good = 1'b0;
        rail_st.led  = 1'b0;
        st = ST_ABSENT;
      end else begin
        seq_start(MODE_CHECK, rail_cfg.rise_budget);
        st = seq_advance(v);
      end
    end else if (op == OP_ON) begin
      rail_st.enable = 1'b1;
      seq_start(MODE_ON, rail_cfg.rise_budget);
      st = seq_advance(v);
    end else if (op == OP_OFF) begin
      rail_st.enable = 1'b0;
      seq_start(MODE_OFF, rail_cfg.fall_budget);
      st = seq_advance(v);
    end
    r.good   = rail_st.good;
    r.enable = rail_st.enable;
    r.led    = rail_st.led ? rail_cfg.led_level : ~rail_cfg.led_level;
    r.busy   = (rail_st.mode != MODE_IDLE);
    r.status = st;
    rail_status_q.push_back(r);
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic send_sample(op_e op, logic [VOLT_W-1:0] v);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    voltage_i  <= v;
    do @(posedge clk_i); while (in_stall_o);
    predict_rail_step(op, v);
  endtask

  task automatic write_reg(reg_idx_e idx, int unsigned val);
    logic [DATA_W-1:0] data;
    data = $urandom;  // bits above the field are junk the block must drop
    case (idx)
      REG_CHECK_THR: begin
        data[THR_W-1:0] = val[THR_W-1:0];
        rail_cfg.check_thr = val[THR_W-1:0];
      end
      REG_ON_THR: begin
        data[THR_W-1:0] = val[THR_W-1:0];
        rail_cfg.on_thr = val[THR_W-1:0];
      end
      REG_OFF_THR: begin
        data[THR_W-1:0] = val[THR_W-1:0];
        rail_cfg.off_thr = val[THR_W-1:0];
      end
      REG_RISE_BUDGET: begin
        data[BUDGET_W-1:0] = val[BUDGET_W-1:0];
        rail_cfg.rise_budget = val[BUDGET_W-1:0];
      end
      REG_FALL_BUDGET: begin
        data[BUDGET_W-1:0] = val[BUDGET_W-1:0];
        rail_cfg.fall_budget = val[BUDGET_W-1:0];
      end
      REG_RUN_NEEDED: begin
        data[RUN_W-1:0] = val[RUN_W-1:0];
        rail_cfg.run_needed = val[RUN_W-1:0];
      end
      default: begin
        data[0] = val[0];
        rail_cfg.led_level = val[0];
      end
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // run any open sequence out with ticks, then wait for every result
  task automatic settle_sequencer();
    while (rail_st.mode != MODE_IDLE) send_sample(OP_TICK, VOLT_W'($urandom));
    in_valid_i <= 1'b0;
    while (rail_status_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_config(int unsigned chk, int unsigned on, int unsigned off,
                              int unsigned rise, int unsigned fall, int unsigned run,
                              int unsigned led);
    settle_sequencer();
    write_reg(REG_CHECK_THR, chk);
    write_reg(REG_ON_THR, on);
    write_reg(REG_OFF_THR, off);
    write_reg(REG_RISE_BUDGET, rise);
    write_reg(REG_FALL_BUDGET, fall);
    write_reg(REG_RUN_NEEDED, run);
    write_reg(REG_LED_LEVEL, led);
  endtask

  // ---------------------------------------------------------------- random items

  function automatic logic [VOLT_W-1:0] volt_above(logic [THR_W-1:0] t);
    return (t == 10'd1023) ? 10'd1023 : VOLT_W'($urandom_range(1023, t + 1));
  endfunction

  function automatic logic [VOLT_W-1:0] volt_at_most(logic [THR_W-1:0] t);
    return VOLT_W'($urandom_range(t, 0));
  endfunction

  // mostly commands that start sequences and ticks that drive them near the thresholds
  task automatic send_random_sample();
    op_e               op;
    mode_e             tgt;
    logic [VOLT_W-1:0] v;
    if (rail_st.mode == MODE_IDLE)
      op = ($urandom_range(99) < 80) ? op_e'($urandom_range(3, 1)) : OP_TICK;
    else
      op = ($urandom_range(99) < 10) ? op_e'($urandom_range(3, 1)) : OP_TICK;
    tgt = (rail_st.mode != MODE_IDLE) ? rail_st.mode : mode_e'(op);
    if ($urandom_range(99) < 15) begin
      v = VOLT_W'($urandom);
    end else begin
      case (tgt)
        MODE_CHECK: v = ($urandom_range(99) < 75) ? volt_above(rail_cfg.check_thr)
                                                  : volt_at_most(rail_cfg.check_thr);
        MODE_ON:    v = ($urandom_range(99) < 75) ? volt_above(rail_cfg.on_thr)
                                                  : volt_at_most(rail_cfg.on_thr);
        MODE_OFF:   v = ($urandom_range(99) < 70) ? VOLT_W'($urandom_range(1023,
                                                      rail_cfg.off_thr))
                                                  : ((rail_cfg.off_thr == 0) ? 10'd0 :
                                                     volt_at_most(rail_cfg.off_thr - 1));
        default:    v = VOLT_W'($urandom);
      endcase
    end
    send_sample(op, v);
  endtask

  task automatic run_phases(int unsigned per_phase);
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 49; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 49; end
        default: begin idle_pct = 8;  stall_pct = 8;  end
      endcase
      repeat (per_phase) send_random_sample();
    end
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string what, int got, int exp_val);
    $display("ERROR: result %0d %s got %0d exp %0d at %0t", result_cnt, what, got, exp_val,
             $realtime);
    mismatch_cnt++;
  endtask

  always @(posedge clk_i) begin
    rail_result_t r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (rail_status_q.size() == 0) begin
        report_mismatch("unexpected item", 1, 0);
      end else begin
        r = rail_status_q.pop_front();
        if (power_good_o !== r.good)   report_mismatch("power_good", power_good_o, r.good);
        if (enable_out_o !== r.enable) report_mismatch("enable_out", enable_out_o, r.enable);
        if (led_pin_o !== r.led)       report_mismatch("led_pin", led_pin_o, r.led);
        if (busy_res_o !== r.busy)     report_mismatch("busy_res", busy_res_o, r.busy);
        if (status_o !== r.status)     report_mismatch("status", status_o, r.status);
      end
      result_cnt++;
    end
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // ---------------------------------------------------------------- tests

  // default registers: every command, boundaries, commands while busy
  task automatic test_directed_defaults();
    send_sample(OP_TICK, 10'd0);
    send_sample(OP_TICK, 10'd1023);
    send_sample(OP_CHECK, 10'd0);      // rail absent
    send_sample(OP_CHECK, 10'd50);     // equal to threshold counts as absent
    send_sample(OP_CHECK, 10'd51);     // check sequence starts
    send_sample(OP_CHECK, 10'd1023);   // ignored, sequence advances
    send_sample(OP_ON, 10'd1023);      // ignored
    repeat (3) send_sample(OP_TICK, 10'd1023);
    send_sample(OP_CHECK, 10'd1023);   // already good: immediate success
    send_sample(OP_ON, 10'd400);
    repeat (4) send_sample(OP_TICK, 10'd401);
    send_sample(OP_OFF, 10'd401);      // ignored, sequence advances
    send_sample(OP_OFF, 10'd1023);
    send_sample(OP_TICK, 10'd40);
    send_sample(OP_TICK, 10'd39);
    send_sample(OP_OFF, 10'd0);        // succeeds on its start sample
  endtask

  // zero budgets and run length act as one; LED polarity inverted
  task automatic test_zero_limits();
    write_config(50, 400, 40, 0, 0, 2, 1);
    send_sample(OP_CHECK, 10'd0);
    send_sample(OP_CHECK, 10'd1023);   // check times out at once, clears LED
    send_sample(OP_ON, 10'd1023);      // power-on timeout keeps flag
    send_sample(OP_OFF, 10'd1023);     // power-off timeout
    write_config(50, 400, 40, 0, 0, 0, 1);
    send_sample(OP_ON, 10'd1023);
    send_sample(OP_CHECK, 10'd1023);
    send_sample(OP_OFF, 10'd0);
    send_sample(OP_OFF, 10'd1023);
  endtask

  task automatic test_random_defaults();
    write_config(CHECK_THR_RST, ON_THR_RST, OFF_THR_RST, RISE_BUDGET_RST,
                 FALL_BUDGET_RST, RUN_NEEDED_RST, LED_LEVEL_RST);
    run_phases(50);
  endtask

  task automatic test_random_floor();
    write_config(0, 0, 0, 0, 0, 0, 0);
    run_phases(50);
  endtask

  task automatic test_random_ceiling();
    write_config(1023, 1023, 1023, 255, 255, 15, 1);
    run_phases(50);
  endtask

  task automatic test_random_spread();
    repeat (5) begin
      write_config($urandom_range(1023), $urandom_range(1023), $urandom_range(1023),
                   $urandom_range(24, 1), $urandom_range(24, 1), $urandom_range(8, 1),
                   $urandom_range(1));
      run_phases(50);
    end
  endtask

  initial begin
    rail_cfg = '{check_thr: CHECK_THR_RST, on_thr: ON_THR_RST, off_thr: OFF_THR_RST,
                 rise_budget: RISE_BUDGET_RST, fall_budget: FALL_BUDGET_RST,
                 run_needed: RUN_NEEDED_RST, led_level: LED_LEVEL_RST};
    rail_st  = '{good: 1'b0, enable: 1'b0, led: 1'b0, mode: MODE_IDLE,
                 high_run: '0, ticks: '0};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_defaults();
    test_zero_limits();
    test_random_defaults();
    test_random_floor();
    test_random_ceiling();
    test_random_spread();

    in_valid_i <= 1'b0;
    while (rail_status_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
